### design/c1ks_pkg.sv
// ----------------------------------------------------------------------------
// c1ks_pkg
// Types, constants and step functions of the Crypto-1 keystream cipher.
// ----------------------------------------------------------------------------
package c1ks_pkg;

  typedef enum logic [2:0] {
    CMD_LOAD      = 3'd0,
    CMD_FWD_BIT   = 3'd1,
    CMD_FWD_WORD  = 3'd2,
    CMD_BACK_BIT  = 3'd3,
    CMD_BACK_WORD = 3'd4
  } c1ks_cmd_e;

  // register index decoded from paddr
  localparam logic REG_CIPHER_KEY = 1'b0;

  localparam logic [23:0] TAPS_ODD  = 24'h29CE5C;
  localparam logic [23:0] TAPS_EVEN = 24'h870804;
  localparam logic [31:0] FILT_TOP  = 32'hEC57E80A;
  localparam logic [19:0] FILT_A    = 20'hF22C0;
  localparam logic [19:0] FILT_B    = 20'h6C9C0;
  localparam logic [19:0] FILT_C    = 20'h3C8B0;
  localparam logic [19:0] FILT_D    = 20'h1E458;
  localparam logic [19:0] FILT_E    = 20'h0D938;

  typedef struct packed {
    logic [23:0] odd;
    logic [23:0] even;
  } c1ks_state_t;

  typedef struct packed {
    c1ks_state_t st;
    logic        ks;
  } c1ks_step_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] data_in;
    logic        feed_keystream;
  } c1ks_item_t;

  typedef struct packed {
    logic [31:0] keystream;
    logic [47:0] state_as_key;
  } c1ks_result_t;

  // two-level nonlinear filter over 20 bits of the odd half
  function automatic logic filter_out(input logic [23:0] x);
    logic [19:0] a;
    logic [19:0] b;
    logic [19:0] c;
    logic [19:0] d;
    logic [19:0] e;
    logic [4:0]  f;
    a = FILT_A >> x[3:0];
    b = FILT_B >> x[7:4];
    c = FILT_C >> x[11:8];
    d = FILT_D >> x[15:12];
    e = FILT_E >> x[19:16];
    f = {a[4], b[3], c[2], d[1], e[0]};
    return FILT_TOP[f];
  endfunction

  function automatic c1ks_step_t step_fwd(input c1ks_state_t s, input logic inbit,
                                          input logic fb);
    c1ks_step_t r;
    logic       v;
    r.ks     = filter_out(s.odd);
    v        = (r.ks & fb) ^ inbit ^ (^(TAPS_ODD & s.odd)) ^ (^(TAPS_EVEN & s.even));
    r.st.odd  = {s.even[22:0], v};
    r.st.even = s.odd;
    return r;
  endfunction

  function automatic c1ks_step_t step_back(input c1ks_state_t s, input logic inbit,
                                           input logic fb);
    c1ks_step_t r;
    logic       v;
    r.st.odd = s.even;
    r.ks     = filter_out(s.even);
    v        = s.odd[0] ^ (^(TAPS_EVEN & {1'b0, s.odd[23:1]})) ^ (^(TAPS_ODD & s.even))
               ^ inbit ^ (r.ks & fb);
    r.st.even = {v, s.odd[23:1]};
    return r;
  endfunction

  // interleaved key bit order into the register pair
  function automatic c1ks_state_t load_key(input logic [47:0] key);
    c1ks_state_t s;
    for (int j = 0; j < 24; j++) begin
      s.odd[j]  = key[6'(2 * j) ^ 6'd7];
      s.even[j] = key[6'(2 * j + 1) ^ 6'd7];
    end
    return s;
  endfunction

  function automatic logic [47:0] pack_key(input c1ks_state_t s);
    logic [47:0] r;
    for (int k = 0; k < 24; k++) begin
      r[6'(2 * k + 1)] = s.odd[5'(k) ^ 5'd3];
      r[6'(2 * k)]     = s.even[5'(k) ^ 5'd3];
    end
    return r;
  endfunction

endpackage

### design/c1ks_in_if.sv
// ----------------------------------------------------------------------------
// c1ks_in_if
// Command channel: valid/ready handshake with command, data and flag.
// ----------------------------------------------------------------------------
interface c1ks_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] data_in;
  logic        feed_keystream;

  modport source (output valid, cmd, data_in, feed_keystream, input ready);
  modport sink   (input valid, cmd, data_in, feed_keystream, output ready);
endinterface

### design/c1ks_out_if.sv
// ----------------------------------------------------------------------------
// c1ks_out_if
// Result channel: valid/ready handshake with keystream and packed state.
// ----------------------------------------------------------------------------
interface c1ks_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] keystream;
  logic [47:0] state_as_key;

  modport source (output valid, keystream, state_as_key, input ready);
  modport sink   (input valid, keystream, state_as_key, output ready);
endinterface

### design/c1ks_apb.sv
// ----------------------------------------------------------------------------
// c1ks_apb
// APB register slave holding the 48-bit cipher key.
// ----------------------------------------------------------------------------
module c1ks_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output logic [47:0] key_o
);

  logic [47:0] key_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[3] == c1ks_pkg::REG_CIPHER_KEY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (wr_en) begin
      key_q <= pwdata[47:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3])
      c1ks_pkg::REG_CIPHER_KEY: begin
        prdata = {16'h0000, key_q};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  assign key_o = key_q;

endmodule

### design/c1ks_core.sv
// ----------------------------------------------------------------------------
// c1ks_core
// Register pair of the Crypto-1 LFSR with the single-pass step logic.
// ----------------------------------------------------------------------------
module c1ks_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  c1ks_pkg::c1ks_item_t   item_i,
  input  logic [47:0]            key_i,
  output c1ks_pkg::c1ks_result_t res_o
);

  c1ks_pkg::c1ks_state_t state_q;
  c1ks_pkg::c1ks_state_t state_d;
  logic [31:0]           ks;

  always_comb begin
    c1ks_pkg::c1ks_step_t r;
    state_d = state_q;
    ks      = '0;
    r       = '0;
    unique case (item_i.cmd)
      c1ks_pkg::CMD_LOAD: begin
        state_d = c1ks_pkg::load_key(key_i);
      end
      c1ks_pkg::CMD_FWD_BIT: begin
        r       = c1ks_pkg::step_fwd(state_q, item_i.data_in[0], item_i.feed_keystream);
        state_d = r.st;
        ks[0]   = r.ks;
      end
      c1ks_pkg::CMD_FWD_WORD: begin
        // byte-reversed bit order within the word
        for (int i = 0; i < 32; i++) begin
          r = c1ks_pkg::step_fwd(state_d, item_i.data_in[5'(i) ^ 5'd24],
                                 item_i.feed_keystream);
          state_d = r.st;
          ks[5'(i) ^ 5'd24] = r.ks;
        end
      end
      c1ks_pkg::CMD_BACK_BIT: begin
        r       = c1ks_pkg::step_back(state_q, item_i.data_in[0], item_i.feed_keystream);
        state_d = r.st;
        ks[0]   = r.ks;
      end
      c1ks_pkg::CMD_BACK_WORD: begin
        for (int i = 31; i >= 0; i--) begin
          r = c1ks_pkg::step_back(state_d, item_i.data_in[5'(i) ^ 5'd24],
                                  item_i.feed_keystream);
          state_d = r.st;
          ks[5'(i) ^ 5'd24] = r.ks;
        end
      end
      default: begin
        state_d = state_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (en_i) begin
      state_q <= state_d;
    end
  end

  assign res_o.keystream    = ks;
  assign res_o.state_as_key = c1ks_pkg::pack_key(state_d);

endmodule

### design/crypto1_keystream_cipher.sv
// ----------------------------------------------------------------------------
// crypto1_keystream_cipher
// Crypto-1 stream cipher: load, step and roll back the 48-bit LFSR.
// ----------------------------------------------------------------------------
// Commands arrive on in_i (valid/ready); each one gives exactly one result on
// out_o holding the keystream bits and the LFSR packed in key bit order.
// The key is written over the APB port and taken by the load command.
// An accepted command is held in the input register; the step logic then
// updates the register pair and loads the result register when the output
// is free, and that result register drives out_o. One command per cycle is
// sustained while the receiver takes results; a word command runs its 32
// LFSR and filter steps through the unrolled step chain in a single
// combinational pass, which sets the clock period.
// When the receiver stalls, the result register holds and the input register
// still takes one more command; in_i.ready drops only when both are full.
// Reset clears the key, the register pair and both valid flags.
// ----------------------------------------------------------------------------
module crypto1_keystream_cipher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  c1ks_in_if.sink            in_i,
  c1ks_out_if.source         out_o
);

  logic                   s1_valid_q;
  c1ks_pkg::c1ks_item_t   s1_item_q;
  logic                   out_valid_q;
  c1ks_pkg::c1ks_result_t out_res_q;
  c1ks_pkg::c1ks_result_t core_res;
  c1ks_pkg::c1ks_item_t   in_item;
  logic [47:0]            key;
  logic                   out_free;
  logic                   adv;
  logic                   in_rdy;

  c1ks_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  c1ks_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .item_i (s1_item_q),
    .key_i  (key),
    .res_o  (core_res)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign adv      = s1_valid_q && out_free;
  assign in_rdy   = !s1_valid_q || adv;

  assign in_item.cmd            = in_i.cmd;
  assign in_item.data_in        = in_i.data_in;
  assign in_item.feed_keystream = in_i.feed_keystream;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_rdy) begin
      s1_item_q <= in_item;
    end
    if (adv) begin
      out_res_q <= core_res;
    end
  end

  assign in_i.ready         = in_rdy;
  assign out_o.valid        = out_valid_q;
  assign out_o.keystream    = out_res_q.keystream;
  assign out_o.state_as_key = out_res_q.state_as_key;

endmodule

### design/c1ks_checker.sv
// ----------------------------------------------------------------------------
// c1ks_checker
// Port-level checks on the command and result channels of the cipher.
// ----------------------------------------------------------------------------
module c1ks_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // an empty output side never blocks commands
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("command channel stalled with no result pending");

  // every command transfer is followed by a valid result on the result channel
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##2 out_valid_i)
    else $error("no result two cycles after a command transfer");

  // a result only shows up after a command
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_xfer, 2))
    else $error("result appeared without a command transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

endmodule

bind crypto1_keystream_cipher c1ks_checker u_c1ks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);
